// ----- hw/rtl/sprite_flipbook_stepper_assert.svh -----
// Assertion macros for the sprite flipbook stepper checker.
// No dependencies; taken in by the checker file.
`ifndef SPRITE_FLIPBOOK_STEPPER_ASSERT_SVH
`define SPRITE_FLIPBOOK_STEPPER_ASSERT_SVH

// same-cycle implication
`define SFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/sfs_pkg.sv -----
// Shared types and constants for the sprite flipbook stepper.
// No dependencies.
`timescale 1ns / 1ps
package sfs_pkg;

	localparam int RAND_W     = 16;
	localparam int DIV_BITS   = 4;
	localparam int DIV_CYCLES = RAND_W / DIV_BITS;
	localparam int CNT_W      = $clog2(DIV_CYCLES);

	localparam logic [2:0] REG_STEP_MODE  = 3'd0;
	localparam logic [2:0] REG_WRAP_MODE  = 3'd1;
	localparam logic [2:0] REG_GRID_COLS  = 3'd2;
	localparam logic [2:0] REG_GRID_ROWS  = 3'd3;
	localparam logic [2:0] REG_THROTTLE   = 3'd4;

	localparam logic [2:0] MODE_RANDOM    = 3'd0;
	localparam logic [2:0] MODE_COL_UP    = 3'd1;
	localparam logic [2:0] MODE_COL_DOWN  = 3'd2;
	localparam logic [2:0] MODE_ROW_DOWN  = 3'd3;
	localparam logic [2:0] MODE_ROW_UP    = 3'd4;

	localparam logic [1:0] WRAP_NONE      = 2'd0;
	localparam logic [1:0] WRAP_INC       = 2'd1;
	localparam logic [1:0] WRAP_DEC       = 2'd2;
	localparam logic [1:0] WRAP_CLAMP     = 2'd3;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic load_out;
	} sfs_cmd_t;

	typedef struct packed {
		logic particle;
		logic need_div;
	} sfs_stat_t;

endpackage

// ----- hw/rtl/sfs_ctrl.sv -----
// Sequencer for the sprite flipbook stepper: accept, remainder steps, result load.
// Depends on sfs_pkg.
`timescale 1ns / 1ps
module sfs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  sfs_pkg::sfs_stat_t stat,
	output sfs_pkg::sfs_cmd_t  cmd
);
	import sfs_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign cmd.accept   = in_valid && in_ready;
	assign cmd.div_step = (state_q == S_DIV);
	assign cmd.load_out = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.accept && stat.particle) begin
						cnt_q   <= '0;
						state_q <= stat.need_div ? S_DIV : S_FIN;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_CYCLES - 1))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (cmd.load_out)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/sfs_datapath.sv -----
// Datapath: configuration registers, throttle countdown, remainder unit and cell step.
// Depends on sfs_pkg.
`timescale 1ns / 1ps
module sfs_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [2:0]       cfg_index,
	input  logic [23:0]      cfg_data,
	input  logic             kind,
	input  logic [15:0]      frame_time,
	input  logic [7:0]       col_index,
	input  logic [7:0]       row_index,
	input  logic [15:0]      random_col,
	input  logic [15:0]      random_row,
	input  sfs_pkg::sfs_cmd_t  cmd,
	output sfs_pkg::sfs_stat_t stat,
	output logic [7:0]       new_col,
	output logic [7:0]       new_row
);
	import sfs_pkg::*;

	logic [2:0]  step_mode_q;
	logic [1:0]  wrap_mode_q;
	logic [8:0]  grid_cols_q;
	logic [8:0]  grid_rows_q;
	logic [23:0] throttle_period_q;
	logic signed [24:0] throttle_left_q;
	logic        advance_q;

	logic [7:0]        col_q, row_q;
	logic [RAND_W-1:0] dcol_q, drow_q;
	logic [7:0]        rcol_q, rrow_q;
	logic [7:0]        new_col_q, new_row_q;

	logic [8:0]  cols, rows;
	logic [8:0]  c, r;
	logic [7:0]  rcol_nx, rrow_nx;
	logic signed [25:0] left_nx;

	function automatic logic [8:0] gsize(input logic [8:0] v);
		if (v == 9'd0)
			return 9'd1;
		else if (v > 9'd256)
			return 9'd256;
		else
			return v;
	endfunction

	function automatic logic [8:0] up_f(input logic [8:0] idx, input logic [8:0] n);
		logic [8:0] t;
		t = idx + 9'd1;
		return (t >= n) ? 9'd0 : t;
	endfunction

	function automatic logic [8:0] down_f(input logic [8:0] idx, input logic [8:0] n);
		return (idx == 9'd0) ? n - 9'd1 : idx - 9'd1;
	endfunction

	function automatic logic [8:0] carry_f(input logic [8:0] idx, input logic [8:0] n,
			input logic [1:0] wm);
		case (wm)
			WRAP_INC: return up_f(idx, n);
			WRAP_DEC: return down_f(idx, n);
			default:  return idx;
		endcase
	endfunction

	// DIV_BITS restoring steps of a remainder by d
	function automatic logic [7:0] rem_f(input logic [7:0] rem, input logic [DIV_BITS-1:0] bits,
			input logic [8:0] d);
		logic [8:0] t;
		logic [7:0] rr;
		rr = rem;
		for (int i = DIV_BITS - 1; i >= 0; i--) begin
			t = {rr, bits[i]};
			if (t >= d)
				t = t - d;
			rr = t[7:0];
		end
		return rr;
	endfunction

	assign cols = gsize(grid_cols_q);
	assign rows = gsize(grid_rows_q);

	assign stat.particle = kind;
	assign stat.need_div = kind && advance_q && (step_mode_q == MODE_RANDOM);

	assign rcol_nx = rem_f(rcol_q, dcol_q[RAND_W-1 -: DIV_BITS], cols);
	assign rrow_nx = rem_f(rrow_q, drow_q[RAND_W-1 -: DIV_BITS], rows);

	assign left_nx = 26'(throttle_left_q) - $signed({10'd0, frame_time});

	always_comb begin
		c = {1'b0, col_q};
		r = {1'b0, row_q};
		if (advance_q) begin
			case (step_mode_q)
				MODE_RANDOM: begin
					c = {1'b0, rcol_q};
					r = {1'b0, rrow_q};
				end
				MODE_COL_UP: begin
					if (cols > 9'd1) begin
						c = c + 9'd1;
						if (c >= cols) begin
							c = 9'd0;
							if (wrap_mode_q == WRAP_CLAMP) begin
								r = r + 9'd1;
								if (r >= rows) begin
									r = rows - 9'd1;
									c = cols - 9'd1;
								end
							end else begin
								r = carry_f(r, rows, wrap_mode_q);
							end
						end
					end
				end
				MODE_COL_DOWN: begin
					if (cols > 9'd1) begin
						if (c == 9'd0)
							r = carry_f(r, rows, wrap_mode_q);
						c = down_f(c, cols);
					end
				end
				MODE_ROW_DOWN: begin
					if (rows > 9'd1) begin
						if (r == 9'd0)
							c = carry_f(c, cols, wrap_mode_q);
						r = down_f(r, rows);
					end
				end
				MODE_ROW_UP: begin
					if (rows > 9'd1) begin
						if (r + 9'd1 >= rows)
							c = carry_f(c, cols, wrap_mode_q);
						r = up_f(r, rows);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_mode_q       <= MODE_COL_UP;
			wrap_mode_q       <= WRAP_INC;
			grid_cols_q       <= 9'd1;
			grid_rows_q       <= 9'd1;
			throttle_period_q <= '0;
			throttle_left_q   <= '0;
			advance_q         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_STEP_MODE: step_mode_q       <= cfg_data[2:0];
					REG_WRAP_MODE: wrap_mode_q       <= cfg_data[1:0];
					REG_GRID_COLS: grid_cols_q       <= cfg_data[8:0];
					REG_GRID_ROWS: grid_rows_q       <= cfg_data[8:0];
					REG_THROTTLE:  throttle_period_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept && !kind) begin
				if (throttle_period_q != 24'd0) begin
					if (left_nx > 26'sd0) begin
						throttle_left_q <= left_nx[24:0];
						advance_q       <= 1'b0;
					end else begin
						throttle_left_q <= $signed({1'b0, throttle_period_q});
						advance_q       <= 1'b1;
					end
				end else begin
					advance_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && kind) begin
			col_q  <= col_index;
			row_q  <= row_index;
			dcol_q <= random_col;
			drow_q <= random_row;
			rcol_q <= '0;
			rrow_q <= '0;
		end else if (cmd.div_step) begin
			dcol_q <= dcol_q << DIV_BITS;
			drow_q <= drow_q << DIV_BITS;
			rcol_q <= rcol_nx;
			rrow_q <= rrow_nx;
		end
		if (cmd.load_out) begin
			new_col_q <= c[7:0];
			new_row_q <= r[7:0];
		end
	end

	assign new_col = new_col_q;
	assign new_row = new_row_q;

endmodule

// ----- hw/rtl/sprite_flipbook_stepper.sv -----
// Sprite flipbook stepper: advances each particle's atlas cell per animation frame.
// Input channel in_valid/in_ready carries frame ticks (kind 0) and particles (kind 1);
// output channel out_valid/out_ready carries one beat per particle, none per tick.
// Configuration channel cfg_valid/cfg_ready (always ready) writes register cfg_index:
//   0 step_mode, 1 wrap_mode, 2 grid_cols, 3 grid_rows, 4 throttle_period.
// A frame tick updates the advance flag and, when a throttle period is set, the countdown.
// A particle's result is registered from its final step once the output register is free;
// in random mode on an advancing frame it first runs the remainder steps, where a column
// and a row remainder unit each retire 4 dividend bits per cycle over 16-bit random words.
// One item is in flight at a time; in_ready is high whenever the sequencer is idle,
// including while a finished result waits in the output register.
// If the receiver stalls, the result is held and a following particle waits in its
// final step until the output register is free.
// Reset clears the throttle, the advance flag and the result valid, and loads the
// register defaults; particles before any tick return their cell unchanged.
// Depends on sfs_pkg, sfs_ctrl and sfs_datapath.
`timescale 1ns / 1ps
module sprite_flipbook_stepper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [15:0] frame_time,
	input  logic [7:0]  col_index,
	input  logic [7:0]  row_index,
	input  logic [15:0] random_col,
	input  logic [15:0] random_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  new_col,
	output logic [7:0]  new_row
);
	import sfs_pkg::*;

	sfs_cmd_t  cmd;
	sfs_stat_t stat;

	assign cfg_ready = 1'b1;

	sfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sfs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.kind       (kind),
		.frame_time (frame_time),
		.col_index  (col_index),
		.row_index  (row_index),
		.random_col (random_col),
		.random_row (random_row),
		.cmd        (cmd),
		.stat       (stat),
		.new_col    (new_col),
		.new_row    (new_row)
	);

endmodule

// ----- hw/rtl/sfs_checker.sv -----
// Port-level checker for the sprite flipbook stepper, bound to the top level.
// Depends on sprite_flipbook_stepper_assert.svh.
`timescale 1ns / 1ps
`include "sprite_flipbook_stepper_assert.svh"
module sfs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic kind,
	input logic out_valid,
	input logic out_ready
);

	`SFS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SFS_ASSERT_NEXT(a_tick_silent, clk, arst_n, in_valid && in_ready && !kind && !out_valid, !out_valid)
	`SFS_ASSERT_NEXT(a_particle_busy, clk, arst_n, in_valid && in_ready && kind, !in_ready)
	`SFS_ASSERT_IMPL(a_result_after_work, clk, arst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind sprite_flipbook_stepper sfs_checker u_sfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready)
);

// ----- sim/tb_sprite_flipbook_stepper.sv -----
// Self-checking testbench for sprite_flipbook_stepper: directed and random frame ticks and
// particles, random gaps on both channels, results checked against an in-bench cell predictor.
// Depends on sfs_pkg and the sprite_flipbook_stepper RTL.
`timescale 1ns / 1ps
module tb_sprite_flipbook_stepper;
	import sfs_pkg::*;

	localparam logic       KIND_TICK       = 1'b0;
	localparam logic       KIND_PARTICLE   = 1'b1;
	localparam logic [2:0] MODE_SPARE      = 3'd7;
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
	localparam logic [23:0] PERIOD_MAX     = 24'hFFFFFF;
	localparam int SETTLE_CYCLES   = 12;
	localparam int LIMIT_CYCLES    = 400000;
	localparam int RANDOM_ITEMS    = 1030;

	typedef struct packed {
		logic [7:0] col;
		logic [7:0] row;
	} atlas_pos_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [15:0] frame_time = '0;
	logic [7:0]  col_index = '0;
	logic [7:0]  row_index = '0;
	logic [15:0] random_col = '0;
	logic [15:0] random_row = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  new_col;
	logic [7:0]  new_row;

	sprite_flipbook_stepper dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .frame_time(frame_time),
		.col_index(col_index), .row_index(row_index),
		.random_col(random_col), .random_row(random_row),
		.out_valid(out_valid), .out_ready(out_ready), .new_col(new_col), .new_row(new_row)
	);

	always #6 clk = ~clk;

	// predictor copy of registers and throttle state
	logic [2:0]  pred_mode = MODE_COL_UP;
	logic [1:0]  pred_wrap = WRAP_INC;
	logic [8:0]  pred_cols = 9'd1;
	logic [8:0]  pred_rows = 9'd1;
	logic [23:0] pred_period = '0;
	int          countdown = 0;
	bit          advancing = 1'b0;

	atlas_pos_t expected_pos[$];
	int  errors = 0;
	int  items_sent = 0;
	int  beats_checked = 0;
	int  settings_used = 0;
	int  cycle_count = 0;
	bit  idle_en = 1'b0;
	int  stall_left = 0;
	int  ft_cap = 65535;

	function automatic int unsigned eff_size(logic [8:0] v);
		if (v == 9'd0) return 1;
		if (v > 9'd256) return 256;
		return v;
	endfunction

	function automatic bit fwd_step(inout int unsigned idx, input int unsigned n);
		idx = idx + 1;
		if (idx >= n) begin
			idx = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit back_step(inout int unsigned idx, input int unsigned n);
		if (idx == 0) begin
			idx = n - 1;
			return 1'b1;
		end
		idx = idx - 1;
		return 1'b0;
	endfunction

	function automatic void carry_into(inout int unsigned idx, input int unsigned n);
		if (pred_wrap == WRAP_INC) void'(fwd_step(idx, n));
		else if (pred_wrap == WRAP_DEC) void'(back_step(idx, n));
	endfunction

	function automatic int draw_wait();
		return idle_en ? $urandom_range(0, 4) : 0;
	endfunction

	task automatic predict_item(input logic k, input logic [15:0] ft, input logic [7:0] c,
			input logic [7:0] r, input logic [15:0] rc, input logic [15:0] rr);
		int unsigned col, row, ncols, nrows;
		atlas_pos_t pos;
		if (k == KIND_TICK) begin
			advancing = 1'b1;
			if (pred_period != 0) begin
				countdown = countdown - int'(ft);
				if (countdown > 0) advancing = 1'b0;
				else countdown = int'(pred_period);
			end
			return;
		end
		col = c;
		row = r;
		if (advancing) begin
			ncols = eff_size(pred_cols);
			nrows = eff_size(pred_rows);
			case (pred_mode)
				MODE_RANDOM: begin
					col = rc % ncols;
					row = rr % nrows;
				end
				MODE_COL_UP: begin
					if (ncols > 1 && fwd_step(col, ncols)) begin
						if (pred_wrap == WRAP_CLAMP) begin
							row = row + 1;
							if (row >= nrows) begin
								row = nrows - 1;
								col = ncols - 1;
							end
						end else begin
							carry_into(row, nrows);
						end
					end
				end
				MODE_COL_DOWN: if (ncols > 1 && back_step(col, ncols)) carry_into(row, nrows);
				MODE_ROW_DOWN: if (nrows > 1 && back_step(row, nrows)) carry_into(col, ncols);
				MODE_ROW_UP:   if (nrows > 1 && fwd_step(row, nrows)) carry_into(col, ncols);
				default: ;
			endcase
		end
		pos.col = col[7:0];
		pos.row = row[7:0];
		expected_pos.push_back(pos);
	endtask

	task automatic send_item(input logic k, input logic [15:0] ft, input logic [7:0] c,
			input logic [7:0] r, input logic [15:0] rc, input logic [15:0] rr);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind       <= k;
		frame_time <= ft;
		col_index  <= c;
		row_index  <= r;
		random_col <= rc;
		random_row <= rr;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (!(in_valid && in_ready)) @(posedge clk);
		items_sent++;
		predict_item(k, ft, c, r, rc, rr);
	endtask

	task automatic send_tick(input logic [15:0] ft);
		send_item(KIND_TICK, ft, 8'($urandom()), 8'($urandom()), 16'($urandom()),
			16'($urandom()));
	endtask

	task automatic send_particle(input logic [7:0] c, input logic [7:0] r);
		send_item(KIND_PARTICLE, 16'($urandom()), c, r, 16'($urandom()), 16'($urandom()));
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready)) @(posedge clk);
		case (idx)
			REG_STEP_MODE: pred_mode   = data[2:0];
			REG_WRAP_MODE: pred_wrap   = data[1:0];
			REG_GRID_COLS: pred_cols   = data[8:0];
			REG_GRID_ROWS: pred_rows   = data[8:0];
			REG_THROTTLE:  pred_period = data;
			default: ;
		endcase
	endtask

	// registers change only once every result is back and the block has settled
	task automatic set_config(input logic [2:0] mode, input logic [1:0] wrap,
			input logic [23:0] cols, input logic [23:0] rows, input logic [23:0] period,
			input bit spare);
		if (in_valid) in_valid <= 1'b0;
		while (expected_pos.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_STEP_MODE, 24'(mode));
		write_reg(REG_WRAP_MODE, 24'(wrap));
		write_reg(REG_GRID_COLS, cols);
		write_reg(REG_GRID_ROWS, rows);
		write_reg(REG_THROTTLE, period);
		if (spare)
			write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 24'($urandom()));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// receiver: random stall before each beat
	always @(posedge clk or negedge arst_n) begin : receiver
		int hold;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				hold = draw_wait();
				stall_left <= hold;
				out_ready  <= (hold == 0);
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= (stall_left == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_beats
		atlas_pos_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pos.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, got col %0d row %0d",
					$time, new_col, new_row);
			end else begin
				want = expected_pos.pop_front();
				beats_checked++;
				if (new_col !== want.col) begin
					errors++;
					$display("%0t: new_col expected %0d got %0d", $time, want.col, new_col);
				end
				if (new_row !== want.row) begin
					errors++;
					$display("%0t: new_row expected %0d got %0d", $time, want.row, new_row);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic test_reset_defaults();
		send_item(KIND_PARTICLE, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_tick(16'h0000);
		send_item(KIND_PARTICLE, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000);
	endtask

	task automatic test_column_step();
		set_config(MODE_COL_UP, WRAP_INC, 24'd4, 24'd3, 24'd0, 1'b0);
		send_tick(16'hFFFF);
		send_particle(8'd3, 8'd2);
		send_particle(8'd200, 8'd255);
		send_particle(8'd0, 8'd0);
	endtask

	task automatic test_clamp();
		set_config(MODE_COL_UP, WRAP_CLAMP, 24'd256, 24'd256, 24'd0, 1'b0);
		send_tick(16'd1);
		send_particle(8'd255, 8'd255);
		send_particle(8'd255, 8'd10);
	endtask

	task automatic test_other_modes();
		set_config(MODE_COL_DOWN, WRAP_DEC, 24'd5, 24'd2, 24'd0, 1'b0);
		send_tick(16'd100);
		send_particle(8'd0, 8'd0);
		set_config(MODE_ROW_DOWN, WRAP_CLAMP, 24'd2, 24'd256, 24'd0, 1'b0);
		send_tick(16'd100);
		send_particle(8'd1, 8'd0);
		set_config(MODE_ROW_UP, WRAP_NONE, 24'd256, 24'h0001FF, 24'd0, 1'b0);
		send_tick(16'd100);
		send_particle(8'd255, 8'd255);
		set_config(MODE_SPARE, WRAP_INC, 24'd4, 24'd4, 24'd0, 1'b0);
		send_tick(16'd100);
		send_particle(8'd3, 8'd3);
	endtask

	task automatic test_random_cells();
		set_config(MODE_RANDOM, WRAP_INC, 24'd0, PERIOD_MAX, 24'd0, 1'b0);
		send_tick(16'd7);
		send_item(KIND_PARTICLE, 16'h0000, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_throttle();
		set_config(MODE_COL_UP, WRAP_NONE, 24'd8, 24'd1, PERIOD_MAX, 1'b1);
		send_tick(16'h0000);
		send_particle(8'd2, 8'd0);
		send_tick(16'hFFFF);
		send_particle(8'd2, 8'd0);
		set_config(MODE_COL_UP, WRAP_NONE, 24'd8, 24'd1, 24'd1, 1'b0);
		send_tick(16'h0000);
		send_particle(8'd5, 8'd0);
	endtask

	function automatic logic [23:0] pick_grid();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel <= 5) return 24'($urandom_range(1, 8));
		if (sel == 6) return 24'd0;
		if (sel == 7) return 24'd256;
		if (sel == 8) return 24'($urandom_range(257, 511));
		return 24'($urandom());
	endfunction

	task automatic random_setting();
		logic [2:0]  mode;
		logic [23:0] period;
		int sel;
		mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(MODE_ROW_UP + 1, MODE_SPARE))
			: 3'($urandom_range(MODE_RANDOM, MODE_ROW_UP));
		sel = $urandom_range(0, 9);
		ft_cap = 65535;
		if (sel <= 3) period = 24'd0;
		else if (sel <= 7) begin
			period = 24'($urandom_range(1, 3000));
			ft_cap = 2000;
		end else if (sel == 8) period = PERIOD_MAX;
		else period = 24'($urandom());
		set_config(mode, 2'($urandom_range(WRAP_NONE, WRAP_CLAMP)), pick_grid(), pick_grid(),
			period, $urandom_range(0, 3) == 0);
	endtask

	task automatic random_tick();
		if ($urandom_range(0, 7) == 0) send_tick(16'($urandom()));
		else send_tick(16'($urandom_range(0, ft_cap)));
	endtask

	task automatic random_particle();
		logic [7:0] c, r;
		if ($urandom_range(0, 4) == 0) c = 8'($urandom());
		else c = 8'($urandom_range(0, eff_size(pred_cols) - 1));
		if ($urandom_range(0, 4) == 0) r = 8'($urandom());
		else r = 8'($urandom_range(0, eff_size(pred_rows) - 1));
		send_particle(c, r);
	endtask

	task automatic test_random_traffic();
		int burst_end, n;
		while (items_sent < RANDOM_ITEMS) begin
			idle_en = ($urandom_range(0, 3) != 0);
			random_setting();
			burst_end = items_sent + $urandom_range(10, 40);
			while (items_sent < burst_end) begin
				if ($urandom_range(0, 4) != 0) begin
					random_tick();
					n = $urandom_range(1, 5);
					repeat (n) random_particle();
				end else if ($urandom_range(0, 1) == 0) begin
					random_tick();
				end else begin
					random_particle();
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_en = 1'b1;
		test_reset_defaults();
		test_column_step();
		test_clamp();
		test_other_modes();
		test_random_cells();
		test_throttle();
		test_random_traffic();
		in_valid <= 1'b0;
		while (expected_pos.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		$display("Sent %0d ticks and particles under %0d register settings, %0d result beats",
			items_sent, settings_used, beats_checked);
		$display("checked field by field with random gaps and stalls on both channels.");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_ctrl.sv
hw/rtl/sfs_datapath.sv
hw/rtl/sprite_flipbook_stepper.sv
hw/rtl/sfs_checker.sv
sim/tb_sprite_flipbook_stepper.sv
